/* hdl/spgs_pkg.sv */
// ----------------------------------------------------------------------------
// Steering PID package
// Shared widths, payload types, register indexes and fixed-point constants
// for the gain-scheduled steering PID.
// ----------------------------------------------------------------------------
package spgs_pkg;

	// Field widths.
	localparam int W_ERR     = 16;
	localparam int W_REG     = 16;
	localparam int W_CFG_IDX = 3;

	// Internal fixed-point widths.
	localparam int W_E     = 24;   // scaled error, Q7.16
	localparam int W_DIFF  = 25;   // error difference before the factor of 100
	localparam int W_DER   = 32;   // derivative, Q.16
	localparam int W_INTEG = 32;   // integral, Q.16
	localparam int W_INC   = 18;   // rounded integral increment
	localparam int W_SUM   = 64;   // controller sum and angle, Q.40

	// Digit-serial multiplier geometry.
	localparam int W_A   = 32;
	localparam int W_B   = 20;
	localparam int DIG   = 4;
	localparam int N_DIG = W_B / DIG;
	localparam int W_CNT = $clog2(N_DIG);
	localparam int W_P   = W_A + W_B;

	localparam int GAIN_FRAC = 12;

	typedef logic signed [W_A-1:0]     mul_a_t;
	typedef logic        [W_B-1:0]     mul_b_t;
	typedef logic signed [W_P-1:0]     mul_p_t;
	typedef logic signed [W_SUM-1:0]   sum_t;
	typedef logic signed [W_E-1:0]     err_t;
	typedef logic signed [W_DER-1:0]   deriv_t;
	typedef logic signed [W_INTEG-1:0] integ_t;

	typedef enum logic [W_CFG_IDX-1:0] {
		REG_GAIN_P_STRAIGHT = 3'd0,
		REG_GAIN_P_CURVE    = 3'd1,
		REG_GAIN_D          = 3'd2,
		REG_ERROR_SCALE     = 3'd3,
		REG_ANGLE_CENTER    = 3'd4,
		REG_ANGLE_MAX       = 3'd5,
		REG_ANGLE_MIN       = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [W_REG-1:0] gain_p_straight;
		logic [W_REG-1:0] gain_p_curve;
		logic [W_REG-1:0] gain_d;
		logic [W_REG-1:0] error_scale;
		logic [W_REG-1:0] angle_center;
		logic [W_REG-1:0] angle_max;
		logic [W_REG-1:0] angle_min;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_p_straight: 16'd2048,
		gain_p_curve:    16'd6963,
		gain_d:          16'd201,
		error_scale:     16'd36864,
		angle_center:    16'd23040,
		angle_max:       16'd28160,
		angle_min:       16'd17920
	};

	typedef struct packed {
		logic signed [W_ERR-1:0] error_sample;
		logic                    integral_enable;
	} sample_t;

	typedef struct packed {
		logic [W_REG-1:0] steer_angle;
		logic             straight_mode;
	} result_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_status_t;

	// Fixed-point constants.
	localparam logic signed [W_ERR-1:0] STRAIGHT_BAND = 16'sd2048;
	localparam mul_b_t ONE_HUNDREDTH_Q24 = 20'd167772;
	localparam logic signed [W_INTEG:0] INTEG_MAX = 33'sd13107200;
	localparam logic signed [W_INTEG:0] INTEG_MIN = -33'sd13107200;
	localparam sum_t TENTH_DEG_Q40 = 64'sd109951162778;

	// Round-half-away offsets: half for positive values, half minus one for negative.
	localparam mul_p_t RND8_POS  = mul_p_t'(128);
	localparam mul_p_t RND8_NEG  = mul_p_t'(127);
	localparam mul_p_t RND24_POS = mul_p_t'(8388608);
	localparam mul_p_t RND24_NEG = mul_p_t'(8388607);
	localparam sum_t   RND32_POS = 64'sd2147483648;
	localparam sum_t   RND32_NEG = 64'sd2147483647;

endpackage

/* hdl/spgs_ser_mul.sv */
// ----------------------------------------------------------------------------
// Digit-serial multiplier
// Signed A times unsigned B, consuming B one radix-16 digit per cycle with a
// narrow add and shifting finished product digits into the B register.
// ----------------------------------------------------------------------------
module spgs_ser_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  spgs_pkg::mul_a_t a,
	input  spgs_pkg::mul_b_t b,
	output logic            done,
	output spgs_pkg::mul_p_t p
);
	import spgs_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [W_CNT-1:0]       cnt_q;
	mul_a_t                 a_q;
	mul_b_t                 lo_q;
	logic signed [W_A:0]    acc_q;
	logic signed [DIG:0]    dig_s;
	logic signed [W_A+DIG:0] pp;
	logic signed [W_A+DIG:0] t;

	assign dig_s = $signed({1'b0, lo_q[DIG-1:0]});
	assign pp    = (W_A+DIG+1)'(a_q) * (W_A+DIG+1)'(dig_s);
	assign t     = (W_A+DIG+1)'(acc_q) + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == W_CNT'(N_DIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The low product digits leave the adder and take the place of the
	// multiplier digits already used.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			lo_q  <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			lo_q  <= {t[DIG-1:0], lo_q[W_B-1:DIG]};
			acc_q <= t[W_A+DIG:DIG];
		end
	end

	assign done = done_q;
	assign p    = $signed({acc_q[W_A-1:0], lo_q});

endmodule

/* hdl/spgs_core.sv */
// ----------------------------------------------------------------------------
// Steering PID sequencer
// Runs the five products of one control tick through the shared serial
// multiplier and keeps the integral and previous-error state.
// ----------------------------------------------------------------------------
module spgs_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  spgs_pkg::sample_t    item,
	input  logic                 take,
	input  spgs_pkg::cfg_t       cfg,
	output spgs_pkg::core_status_t status,
	output spgs_pkg::result_t    res
);
	import spgs_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_E    = 8'b0000_0010,
		ST_I    = 8'b0000_0100,
		ST_P    = 8'b0000_1000,
		ST_D    = 8'b0001_0000,
		ST_K    = 8'b0010_0000,
		ST_R    = 8'b0100_0000,
		ST_C    = 8'b1000_0000
	} state_t;

	state_t   state_q;
	logic     mul_start_q;
	mul_a_t   mul_a_q;
	mul_b_t   mul_b_q;
	logic     mul_done;
	mul_p_t   mul_p;

	logic     en_q;
	logic     straight_q;
	err_t     e_q;
	err_t     prev_q;
	deriv_t   deriv_q;
	integ_t   integ_q;
	sum_t     sum_q;
	sum_t     ang_q;

	logic                     straight_in;
	logic [W_REG-1:0]         kp;
	mul_p_t                   rnd8;
	err_t                     e_new;
	mul_p_t                   rnd24;
	logic signed [W_INC-1:0]  inc;
	logic signed [W_INTEG:0]  integ_sum;
	integ_t                   integ_new;
	logic signed [W_DIFF-1:0] diff;
	deriv_t                   diff_w;
	deriv_t                   deriv_new;
	sum_t                     prod_w;
	sum_t                     center_w;
	sum_t                     rnd32;
	logic signed [31:0]       ang_r;
	logic signed [32:0]       ang_w;
	logic signed [32:0]       lim_max;
	logic signed [32:0]       lim_min;
	logic signed [32:0]       ang_hi;
	logic signed [32:0]       ang_lo;

	spgs_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	// An error of exactly half a unit already counts as a curve.
	assign straight_in = (item.error_sample > -STRAIGHT_BAND) &&
		(item.error_sample < STRAIGHT_BAND);
	assign kp = straight_q ? cfg.gain_p_straight : cfg.gain_p_curve;

	assign rnd8  = mul_p + (mul_p[W_P-1] ? RND8_NEG : RND8_POS);
	assign e_new = rnd8[W_E+7:8];

	assign rnd24     = mul_p + (mul_p[W_P-1] ? RND24_NEG : RND24_POS);
	assign inc       = rnd24[W_INC+23:24];
	assign integ_sum = (W_INTEG+1)'(integ_q) + (W_INTEG+1)'(inc);
	always_comb begin
		if (integ_sum > INTEG_MAX) begin
			integ_new = W_INTEG'(INTEG_MAX);
		end else if (integ_sum < INTEG_MIN) begin
			integ_new = W_INTEG'(INTEG_MIN);
		end else begin
			integ_new = integ_sum[W_INTEG-1:0];
		end
	end

	// Times 100 as 64 + 32 + 4.
	assign diff      = W_DIFF'(e_q) - W_DIFF'(prev_q);
	assign diff_w    = W_DER'(diff);
	assign deriv_new = (diff_w <<< 6) + (diff_w <<< 5) + (diff_w <<< 2);

	assign prod_w   = W_SUM'(mul_p);
	assign center_w = $signed(W_SUM'({cfg.angle_center, 32'b0}));

	assign rnd32   = ang_q + (ang_q[W_SUM-1] ? RND32_NEG : RND32_POS);
	assign ang_r   = rnd32[W_SUM-1:32];
	assign ang_w   = 33'(ang_r);
	assign lim_max = $signed({17'b0, cfg.angle_max});
	assign lim_min = $signed({17'b0, cfg.angle_min});
	assign ang_hi  = (ang_w > lim_max) ? lim_max : ang_w;
	assign ang_lo  = (ang_hi < lim_min) ? lim_min : ang_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			en_q        <= 1'b0;
			straight_q  <= 1'b0;
			e_q         <= '0;
			prev_q      <= '0;
			deriv_q     <= '0;
			integ_q     <= '0;
			sum_q       <= '0;
			ang_q       <= '0;
		end else begin
			mul_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						en_q        <= item.integral_enable;
						straight_q  <= straight_in;
						mul_a_q     <= -mul_a_t'(item.error_sample);
						mul_b_q     <= W_B'(cfg.error_scale);
						mul_start_q <= 1'b1;
						state_q     <= ST_E;
					end
				end
				ST_E: begin
					if (mul_done) begin
						e_q         <= e_new;
						mul_a_q     <= W_A'(e_new);
						mul_b_q     <= ONE_HUNDREDTH_Q24;
						mul_start_q <= 1'b1;
						state_q     <= ST_I;
					end
				end
				ST_I: begin
					if (mul_done) begin
						integ_q     <= integ_new;
						deriv_q     <= deriv_new;
						prev_q      <= e_q;
						mul_a_q     <= W_A'(e_q);
						mul_b_q     <= W_B'(kp);
						mul_start_q <= 1'b1;
						state_q     <= ST_P;
					end
				end
				ST_P: begin
					if (mul_done) begin
						// The tenth-degree offset rides along with the first term.
						sum_q       <= (prod_w <<< GAIN_FRAC) + TENTH_DEG_Q40;
						mul_a_q     <= W_A'(deriv_q);
						mul_b_q     <= W_B'(cfg.gain_d);
						mul_start_q <= 1'b1;
						state_q     <= ST_D;
					end
				end
				ST_D: begin
					if (mul_done) begin
						sum_q       <= sum_q + (prod_w <<< GAIN_FRAC);
						mul_a_q     <= W_A'(integ_q);
						mul_b_q     <= ONE_HUNDREDTH_Q24;
						mul_start_q <= 1'b1;
						state_q     <= ST_K;
					end
				end
				ST_K: begin
					if (mul_done) begin
						if (en_q) begin
							sum_q <= sum_q + prod_w;
						end
						state_q <= ST_R;
					end
				end
				ST_R: begin
					ang_q   <= center_w - sum_q;
					state_q <= ST_C;
				end
				ST_C: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.idle       = (state_q == ST_IDLE);
	assign status.done       = (state_q == ST_C);
	assign res.steer_angle   = ang_lo[W_REG-1:0];
	assign res.straight_mode = straight_q;

endmodule

/* hdl/steering_pid_with_gain_schedule_unit.sv */
// ----------------------------------------------------------------------------
// Gain-scheduled steering PID
// One error sample in, one clamped steering angle out, with register-set gains
// and angle limits.
// ----------------------------------------------------------------------------
// Once the result of a sample is written to the output register, the next
// sample can be taken in the cycle after. The one shared digit-serial
// multiplier works through five products per sample (error scaling, integral
// increment, proportional, derivative and integral terms), each five radix-16
// digits, followed by a state that registers the angle; the clamp behind that
// register is combinational and drives the output register.
// The result waits in an output register, so a finished result that is held by
// result_stall does not keep the next sample from starting. Configuration
// writes are always ready and take effect the next cycle; write them only
// while no sample is in flight.
module steering_pid_with_gain_schedule_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  spgs_pkg::sample_t                 sample,
	output logic                              result_valid,
	input  logic                              result_stall,
	output spgs_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spgs_pkg::W_CFG_IDX-1:0]    cfg_index,
	input  logic [spgs_pkg::W_REG-1:0]        cfg_data
);
	import spgs_pkg::*;

	cfg_t         cfg_q;
	core_status_t core_st;
	result_t      core_res;
	logic         start;
	logic         take;
	logic         res_valid_q;
	result_t      res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAIN_P_STRAIGHT: cfg_q.gain_p_straight <= cfg_data;
				REG_GAIN_P_CURVE:    cfg_q.gain_p_curve    <= cfg_data;
				REG_GAIN_D:          cfg_q.gain_d          <= cfg_data;
				REG_ERROR_SCALE:     cfg_q.error_scale     <= cfg_data;
				REG_ANGLE_CENTER:    cfg_q.angle_center    <= cfg_data;
				REG_ANGLE_MAX:       cfg_q.angle_max       <= cfg_data;
				REG_ANGLE_MIN:       cfg_q.angle_min       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign sample_stall = !core_st.idle;
	assign start        = sample_valid && !sample_stall;
	// The output slot is free when empty or when its result transfers this cycle.
	assign take         = !res_valid_q || !result_stall;

	spgs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (sample),
		.take   (take),
		.cfg    (cfg_q),
		.status (core_st),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (core_st.done && take) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_st.done && take) begin
			res_q <= core_res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

/* hdl/spgs_checker.sv */
// ----------------------------------------------------------------------------
// Steering PID port checker
// Watches the top-level ports for sample/result ordering and output holding.
// ----------------------------------------------------------------------------
module spgs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input logic              result_valid,
	input logic              result_stall,
	input spgs_pkg::result_t result
);
	import spgs_pkg::*;

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pending_q;

	assign in_xfer  = sample_valid && !sample_stall;
	assign out_xfer = result_valid && !result_stall;

	// Samples taken whose results have not yet transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> sample_stall)
		else $error("block took a sample and did not go busy");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two samples outstanding");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> pending_q != 2'd0)
		else $error("result appeared with no sample outstanding");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or was dropped");

endmodule

bind steering_pid_with_gain_schedule_unit spgs_checker u_spgs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Steering PID testbench
// Drives error samples and register writes into the gain-scheduled steering
// PID, predicts every steering angle and gain flag in a scoreboard, and checks
// each result transfer in order under random idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import spgs_pkg::*;

	// Longest quiet stretch in a correct run is the long receiver hold below.
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned IDLE_LIMIT  = 5000;
	localparam int unsigned PRINT_LIMIT = 200;
	localparam logic [W_CFG_IDX-1:0] CFG_IDX_UNUSED = 3'd7;

	typedef enum int {RUN_NOISE, RUN_DRIFT, RUN_EDGE, RUN_STRAIGHT} run_kind_e;

	class steer_checker;
		localparam longint BAND          = 2048;
		localparam longint CENTI_Q24     = 167772;
		localparam longint INTEG_CLAMP   = 13107200;
		localparam longint TENTH_DEG_Q40 = 64'sd109951162778;
		localparam longint ONE_Q32       = 64'sd4294967296;

		cfg_t               regs;
		int                 integ_acc;
		logic signed [23:0] last_err;
		result_t            angle_q[$];
		int unsigned        fails;

		function new();
			regs = CFG_RESET;
			integ_acc = 0;
			last_err = '0;
			fails = 0;
		endfunction

		function void write_reg(logic [W_CFG_IDX-1:0] idx, logic [W_REG-1:0] data);
			case (idx)
				REG_GAIN_P_STRAIGHT: regs.gain_p_straight = data;
				REG_GAIN_P_CURVE:    regs.gain_p_curve = data;
				REG_GAIN_D:          regs.gain_d = data;
				REG_ERROR_SCALE:     regs.error_scale = data;
				REG_ANGLE_CENTER:    regs.angle_center = data;
				REG_ANGLE_MAX:       regs.angle_max = data;
				REG_ANGLE_MIN:       regs.angle_min = data;
				default: ;
			endcase
		endfunction

		// Shift right with rounding to nearest, ties away from zero.
		function longint round_away(longint v, int unsigned sh);
			longint half;
			half = 64'sd1 <<< (sh - 1);
			if (v >= 0)
				return (v + half) >>> sh;
			return -((-v + half) >>> sh);
		endfunction

		function result_t predict_steer(sample_t s);
			longint  x, kp, e, integ, prev, deriv, total, ang;
			bit      straight;
			result_t r;
			x = longint'($signed(s.error_sample));
			straight = (x > -BAND) && (x < BAND);
			kp = straight ? longint'(regs.gain_p_straight) : longint'(regs.gain_p_curve);
			e = round_away(-x * longint'(regs.error_scale), 8);

			integ = longint'(integ_acc) + round_away(e * CENTI_Q24, 24);
			if (integ > INTEG_CLAMP)
				integ = INTEG_CLAMP;
			if (integ < -INTEG_CLAMP)
				integ = -INTEG_CLAMP;
			integ_acc = int'(integ);

			prev = longint'(last_err);
			deriv = 100 * (e - prev);
			last_err = e[23:0];

			total = kp * e * 4096 + longint'(regs.gain_d) * deriv * 4096;
			if (s.integral_enable)
				total += integ * CENTI_Q24;

			ang = round_away(longint'(regs.angle_center) * ONE_Q32 - total - TENTH_DEG_Q40, 32);
			// The upper clamp goes first, so inverted limits end at angle_min.
			if (ang > longint'(regs.angle_max))
				ang = longint'(regs.angle_max);
			if (ang < longint'(regs.angle_min))
				ang = longint'(regs.angle_min);
			r.steer_angle = ang[15:0];
			r.straight_mode = straight;
			return r;
		endfunction

		function void note_sample(sample_t s);
			angle_q.push_back(predict_steer(s));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (angle_q.size() == 0) begin
				fails++;
				if (fails <= PRINT_LIMIT)
					$display("%0t: result with nothing expected, got angle %0d straight %0b",
						$time, got.steer_angle, got.straight_mode);
				return;
			end
			want = angle_q.pop_front();
			if (got.steer_angle !== want.steer_angle) begin
				fails++;
				if (fails <= PRINT_LIMIT)
					$display("%0t: steer_angle expected %0d got %0d",
						$time, want.steer_angle, got.steer_angle);
			end
			if (got.straight_mode !== want.straight_mode) begin
				fails++;
				if (fails <= PRINT_LIMIT)
					$display("%0t: straight_mode expected %0b got %0b",
						$time, want.straight_mode, got.straight_mode);
			end
		endfunction

		function int unsigned pending();
			return angle_q.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [W_CFG_IDX-1:0] cfg_index = '0;
	logic [W_REG-1:0]     cfg_data = '0;

	steer_checker sb = new();
	bit           quiet = 1'b0;
	int unsigned  idle_cycles = 0;

	steering_pid_with_gain_schedule_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned draw_gap();
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic send_sample(sample_t s, int unsigned gap);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	task automatic put_reg(logic [W_CFG_IDX-1:0] idx, logic [W_REG-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_settings(cfg_t c, bit poke_unused);
		put_reg(REG_GAIN_P_STRAIGHT, c.gain_p_straight);
		put_reg(REG_GAIN_P_CURVE, c.gain_p_curve);
		put_reg(REG_GAIN_D, c.gain_d);
		put_reg(REG_ERROR_SCALE, c.error_scale);
		put_reg(REG_ANGLE_CENTER, c.angle_center);
		put_reg(REG_ANGLE_MAX, c.angle_max);
		put_reg(REG_ANGLE_MIN, c.angle_min);
		if (poke_unused)
			put_reg(CFG_IDX_UNUSED, W_REG'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every predicted angle has come back.
	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic cfg_t random_settings();
		cfg_t c;
		c.gain_p_straight = W_REG'($urandom_range(0, 16383));
		c.gain_p_curve = W_REG'($urandom_range(0, 16383));
		c.gain_d = W_REG'($urandom_range(0, 1023));
		c.error_scale = W_REG'($urandom_range(0, 65535));
		c.angle_center = W_REG'($urandom_range(0, 46080));
		c.angle_max = W_REG'($urandom_range(23040, 46080));
		c.angle_min = W_REG'($urandom_range(0, 23040));
		return c;
	endfunction

	// Field extremes and both sides of the straight/curve boundary.
	task automatic run_directed();
		int      pts[20];
		int      i;
		sample_t s;
		pts = '{0, 1, -1, 2047, -2047, 2048, -2048, 2049, -2049, 32767,
			-32768, 32767, -32768, 21845, -21846, 4096, -4096, 32767, 32767, 0};
		for (i = 0; i < 20; i++) begin
			s.error_sample = 16'(pts[i]);
			s.integral_enable = i[0];
			send_sample(s, draw_gap());
		end
	endtask

	// Runs of related samples; long same-sign drifts push the integral into its clamp.
	task automatic run_random(int unsigned count);
		int unsigned done_n, len, i;
		int          mag;
		bit          neg, en_bias;
		run_kind_e   kind;
		sample_t     s;
		done_n = 0;
		while (done_n < count) begin
			kind = run_kind_e'($urandom_range(0, 3));
			len = (kind == RUN_DRIFT) ? $urandom_range(100, 300) : $urandom_range(10, 50);
			neg = 1'($urandom_range(0, 1));
			en_bias = $urandom_range(0, 3) != 0;
			quiet = $urandom_range(0, 4) == 0;
			for (i = 0; i < len && done_n < count; i++) begin
				s.integral_enable = en_bias ? ($urandom_range(0, 7) != 0) :
					($urandom_range(0, 7) == 0);
				case (kind)
					RUN_NOISE: begin
						s.error_sample = 16'($urandom);
					end
					RUN_DRIFT: begin
						mag = $urandom_range(8192, 32767);
						s.error_sample = neg ? 16'(-mag) : 16'(mag);
					end
					RUN_EDGE: begin
						mag = $urandom_range(2040, 2056);
						s.error_sample = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
					end
					default: begin
						s.error_sample = 16'(int'($urandom_range(0, 4094)) - 2047);
					end
				endcase
				send_sample(s, draw_gap());
				done_n++;
			end
		end
		quiet = 1'b0;
	endtask

	// Receiver: a random stall before each result, and two long holds that back
	// the block up until it stalls its input.
	initial begin
		int unsigned hold, taken;
		taken = 0;
		forever begin
			if (taken == 200 || taken == 1000)
				hold = HOLD_CYCLES;
			else
				hold = draw_gap();
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do
				@(posedge clk);
			while (!result_valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL steering_pid_with_gain_schedule_unit");
			$finish;
		end
	end

	initial begin
		int   p;
		cfg_t c;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of every register.
		run_directed();
		drain();

		apply_settings(random_settings(), 1'b1);
		run_random(300);
		drain();

		c = '{gain_p_straight: 16'hFFFF, gain_p_curve: 16'hFFFF, gain_d: 16'hFFFF,
			error_scale: 16'hFFFF, angle_center: 16'd46080, angle_max: 16'd46080,
			angle_min: 16'd0};
		apply_settings(c, 1'b0);
		run_directed();
		run_random(130);
		drain();

		c = '{gain_p_straight: 16'd0, gain_p_curve: 16'd0, gain_d: 16'd0,
			error_scale: 16'd0, angle_center: 16'd46080, angle_max: 16'hFFFF,
			angle_min: 16'd0};
		apply_settings(c, 1'b0);
		run_random(100);
		drain();

		// Inverted limits.
		c = random_settings();
		c.angle_min = W_REG'($urandom_range(30000, 46080));
		c.angle_max = W_REG'($urandom_range(0, 20000));
		apply_settings(c, 1'b1);
		run_random(100);
		drain();

		// Limits and center beyond the nominal angle range.
		c = random_settings();
		c.angle_center = 16'hFFFF;
		c.angle_max = 16'hFFFF;
		c.angle_min = W_REG'($urandom_range(46081, 65535));
		apply_settings(c, 1'b0);
		run_random(100);
		drain();

		for (p = 0; p < 4; p++) begin
			apply_settings(random_settings(), p[0]);
			run_random(250);
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.fails == 0)
			$display("PASS steering_pid_with_gain_schedule_unit");
		else
			$display("FAIL steering_pid_with_gain_schedule_unit");
		$finish;
	end

endmodule
